### src/tss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and constants of the triangle subdivision core.
// ----------------------------------------------------------------------------
package tss_pkg;

  // default vertex coordinate width, signed Q3.12
  localparam int unsigned DEF_COORD_WIDTH = 16;
  // highest legal subdivision count
  localparam logic [3:0]  MAX_FREQ        = 4'd9;
  // output coordinate width and the Q1.14 value of 1.0
  localparam int unsigned OUT_W           = 16;
  localparam logic [15:0] UNIT_ONE        = 16'd16384;
  // iteration counts of the square root and divide units
  localparam int unsigned SQRT_STEPS      = 32;
  localparam int unsigned DIV_STEPS       = 16;
  localparam int unsigned STEP_W          = 5;
  // output packing
  localparam int unsigned OUT_DATA_W      = 56;
  localparam int unsigned OUT_USER_W      = 2;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_TERM,
    OP_ABS,
    OP_RANGE,
    OP_SQ,
    OP_NORM,
    OP_SQRT_INIT,
    OP_SQRT,
    OP_DIV_INIT,
    OP_DIV,
    OP_EMIT
  } op_e;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TERM,
    ST_ABS,
    ST_RANGE,
    ST_SQ,
    ST_NORM,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV,
    ST_EMIT
  } state_e;

  // command from controller to datapath
  typedef struct packed {
    op_e        op;
    logic [1:0] idx;
    logic [3:0] row;
    logic [3:0] col;
    logic [3:0] freq;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic over;
    logic sum_zero;
    logic x_low;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

### src/triangle_subdivide_to_sphere_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_subdivide_to_sphere_core
// Subdivides a triangle into a grid and projects each point onto the sphere.
// ----------------------------------------------------------------------------
// Usage:
//   A triangle request enters on the s_axis channel (nine signed Q3.12
//   coordinates). For frequency v the core emits (v+1)(v+2)/2 points on
//   m_axis, row by row, each a Q1.14 unit vector (all zero if degenerate)
//   with row, column, corner and degenerate flags; tlast marks the final point.
//   The frequency register is to be written by the user through
//   cfg_we_i/cfg_wdata_i only while no triangle is in flight; the core
//   itself does not enforce this. 0 acts as 1, values above 9 as 9.
//   Per point the core forms the grid vector, takes the magnitudes, does
//   the range check and square sum, normalizes, runs the bit-serial square
//   root and the three parallel dividers, and loads the output register; a
//   zero-length point goes from the square sum straight to the output
//   register. A triangle request is taken in the idle state, and a new
//   request is taken once the last point is in the output register.
//   When the receiver stalls, the finished point waits in the output
//   register and the sequencer holds before loading the next point.
//   Reset empties the output register, returns to idle and sets frequency 1.
// ----------------------------------------------------------------------------
module triangle_subdivide_to_sphere_core #(
  parameter int unsigned COORD_WIDTH = tss_pkg::DEF_COORD_WIDTH,
  localparam int unsigned IN_DATA_W  = ((9 * COORD_WIDTH + 7) / 8) * 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // frequency register
  input  wire logic                          cfg_we_i,
  input  wire logic [3:0]                    cfg_wdata_i,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from the lowest bit up
  input  wire logic [IN_DATA_W-1:0]          s_axis_tdata,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // px, py, pz, row, col from the lowest bit up
  output logic [tss_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // is_corner, degenerate from the lowest bit up
  output logic [tss_pkg::OUT_USER_W-1:0]     m_axis_tuser,
  output logic                               m_axis_tlast,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready
);

  tss_pkg::cmd_t    cmd;
  tss_pkg::status_t status;

  // sequencer
  tss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic
  tss_dp #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata[9*COORD_WIDTH-1:0]),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser),
    .out_last_o  (m_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready)
  );

endmodule
`default_nettype wire

### src/tss_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tss_ctrl
// Sequencer: frequency register, grid row/column walk and per-point steps.
// ----------------------------------------------------------------------------
module tss_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [3:0]      cfg_wdata_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire tss_pkg::status_t status_i,
  output tss_pkg::cmd_t        cmd_o
);

  tss_pkg::state_e state_q, state_d;
  logic [3:0] freq_q;
  logic [3:0] row_q, row_d;
  logic [3:0] col_q, col_d;
  logic [tss_pkg::STEP_W-1:0] step_q, step_d;
  logic [3:0] v;
  logic       at_last;

  // effective frequency, clamped to the legal range
  always_comb begin
    if (freq_q == 4'd0) begin
      v = 4'd1;
    end else if (freq_q > tss_pkg::MAX_FREQ) begin
      v = tss_pkg::MAX_FREQ;
    end else begin
      v = freq_q;
    end
  end

  assign at_last = (row_q == v) && (col_q == v);

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tss_pkg::ST_IDLE;
      freq_q  <= 4'd1;
      row_q   <= '0;
      col_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      step_q  <= step_d;
      if (cfg_we_i) begin
        freq_q <= cfg_wdata_i;
      end
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    col_d      = col_q;
    step_d     = step_q;
    in_ready_o = 1'b0;
    cmd_o.op   = tss_pkg::OP_NONE;
    cmd_o.idx  = step_q[1:0];
    cmd_o.row  = row_q;
    cmd_o.col  = col_q;
    cmd_o.freq = v;
    case (state_q)
      tss_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = tss_pkg::OP_LATCH;
          row_d    = '0;
          col_d    = '0;
          step_d   = '0;
          state_d  = tss_pkg::ST_TERM;
        end
      end
      tss_pkg::ST_TERM: begin
        cmd_o.op = tss_pkg::OP_TERM;
        if (step_q == tss_pkg::STEP_W'(2)) begin
          step_d  = '0;
          state_d = tss_pkg::ST_ABS;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      tss_pkg::ST_ABS: begin
        cmd_o.op = tss_pkg::OP_ABS;
        state_d  = tss_pkg::ST_RANGE;
      end
      tss_pkg::ST_RANGE: begin
        if (status_i.over) begin
          cmd_o.op = tss_pkg::OP_RANGE;
        end else begin
          step_d  = '0;
          state_d = tss_pkg::ST_SQ;
        end
      end
      tss_pkg::ST_SQ: begin
        cmd_o.op = tss_pkg::OP_SQ;
        if (step_q == tss_pkg::STEP_W'(3)) begin
          step_d  = '0;
          state_d = tss_pkg::ST_NORM;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      tss_pkg::ST_NORM: begin
        if (status_i.sum_zero) begin
          state_d = tss_pkg::ST_EMIT;
        end else if (status_i.x_low) begin
          cmd_o.op = tss_pkg::OP_NORM;
        end else begin
          state_d = tss_pkg::ST_SQRT_INIT;
        end
      end
      tss_pkg::ST_SQRT_INIT: begin
        cmd_o.op = tss_pkg::OP_SQRT_INIT;
        step_d   = '0;
        state_d  = tss_pkg::ST_SQRT;
      end
      tss_pkg::ST_SQRT: begin
        cmd_o.op = tss_pkg::OP_SQRT;
        if (step_q == tss_pkg::STEP_W'(tss_pkg::SQRT_STEPS - 1)) begin
          step_d  = '0;
          state_d = tss_pkg::ST_DIV_INIT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      tss_pkg::ST_DIV_INIT: begin
        cmd_o.op = tss_pkg::OP_DIV_INIT;
        step_d   = '0;
        state_d  = tss_pkg::ST_DIV;
      end
      tss_pkg::ST_DIV: begin
        cmd_o.op = tss_pkg::OP_DIV;
        if (step_q == tss_pkg::STEP_W'(tss_pkg::DIV_STEPS - 1)) begin
          step_d  = '0;
          state_d = tss_pkg::ST_EMIT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      tss_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.op = tss_pkg::OP_EMIT;
          step_d   = '0;
          if (at_last) begin
            row_d   = '0;
            col_d   = '0;
            state_d = tss_pkg::ST_IDLE;
          end else begin
            if (col_q == row_q) begin
              row_d = row_q + 1'b1;
              col_d = '0;
            end else begin
              col_d = col_q + 1'b1;
            end
            state_d = tss_pkg::ST_TERM;
          end
        end
      end
      default: begin
        state_d = tss_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### src/tss_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tss_dp
// Datapath: vertex latch, grid point, square sum, square root, divide, output.
// ----------------------------------------------------------------------------
module tss_dp #(
  parameter int unsigned COORD_WIDTH = tss_pkg::DEF_COORD_WIDTH
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire tss_pkg::cmd_t                     cmd_i,
  output tss_pkg::status_t                       status_o,
  input  wire logic [9*COORD_WIDTH-1:0]          in_data_i,
  output logic [tss_pkg::OUT_DATA_W-1:0]         out_data_o,
  output logic [tss_pkg::OUT_USER_W-1:0]         out_user_o,
  output logic                                   out_last_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i
);

  localparam int unsigned NW  = COORD_WIDTH + 4;
  localparam int unsigned MW  = COORD_WIDTH + 3;
  localparam int unsigned MMW = (MW > 31) ? MW : 31;
  localparam int unsigned PW  = COORD_WIDTH + 5;

  logic signed [COORD_WIDTH-1:0] vtx_q [9];
  logic signed [NW-1:0]          n_q [3];
  logic [MMW-1:0]                m_q [3];
  logic                          neg_q [3];
  logic [30:0]                   m31 [3];
  logic [61:0]                   prod_q;
  logic [63:0]                   sum_q;
  logic [63:0]                   x_q;
  logic [4:0]                    s_q;
  logic [63:0]                   rem_q;
  logic [63:0]                   res_q;
  logic [63:0]                   bit_q;
  logic [47:0]                   drem_q [3];
  logic [47:0]                   ds_q;
  logic [15:0]                   quo_q [3];
  logic                          out_valid_q;
  logic [tss_pkg::OUT_DATA_W-1:0] out_data_q;
  logic [tss_pkg::OUT_USER_W-1:0] out_user_q;
  logic                          out_last_q;

  logic [3:0]                    weight;
  logic signed [COORD_WIDTH-1:0] sel [3];
  logic signed [PW-1:0]          term [3];
  logic [NW-1:0]                 mag [3];
  logic [30:0]                   sq_sel;
  logic [61:0]                   sq;
  logic [63:0]                   acc;
  logic [63:0]                   root_try;
  logic [63:0]                   num [3];
  logic [15:0]                   qc [3];
  logic [15:0]                   pc [3];
  logic                          degen;
  logic                          corner;
  logic                          last;
  logic                          over;

  // term weight and vertex choice
  always_comb begin
    case (cmd_i.idx)
      2'd0:    weight = cmd_i.freq - cmd_i.row;
      2'd1:    weight = cmd_i.row - cmd_i.col;
      default: weight = cmd_i.col;
    endcase
    for (int c = 0; c < 3; c++) begin
      case (cmd_i.idx)
        2'd0:    sel[c] = vtx_q[c];
        2'd1:    sel[c] = vtx_q[3+c];
        default: sel[c] = vtx_q[6+c];
      endcase
      term[c] = $signed({1'b0, weight}) * sel[c];
      mag[c]  = n_q[c][NW-1] ? NW'(-n_q[c]) : NW'(n_q[c]);
      m31[c]  = m_q[c][30:0];
    end
  end

  // range check of the magnitudes
  always_comb begin
    over = 1'b0;
    for (int c = 0; c < 3; c++) begin
      over = over | ((m_q[c] >> 31) != '0);
    end
  end

  // square and accumulate
  always_comb begin
    case (cmd_i.idx)
      2'd0:    sq_sel = m31[0];
      2'd1:    sq_sel = m31[1];
      default: sq_sel = m31[2];
    endcase
    sq       = 62'(sq_sel) * 62'(sq_sel);
    acc      = ((cmd_i.idx == 2'd1) ? 64'd0 : sum_q) + 64'(prod_q);
    root_try = res_q + bit_q;
  end

  // divide set-up, rounding and sign
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num[c] = ((64'(m31[c]) << s_q) << 15) + 64'(res_q[31:0]);
      qc[c]  = (quo_q[c] > tss_pkg::UNIT_ONE) ? tss_pkg::UNIT_ONE : quo_q[c];
      pc[c]  = neg_q[c] ? (16'd0 - qc[c]) : qc[c];
    end
    degen  = (x_q == 64'd0);
    last   = (cmd_i.row == cmd_i.freq) && (cmd_i.col == cmd_i.freq);
    corner = (cmd_i.row == 4'd0) ||
             ((cmd_i.row == cmd_i.freq) && ((cmd_i.col == 4'd0) || last));
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      tss_pkg::OP_LATCH: begin
        for (int i = 0; i < 9; i++) begin
          vtx_q[i] <= $signed(in_data_i[i*COORD_WIDTH +: COORD_WIDTH]);
        end
      end
      tss_pkg::OP_TERM: begin
        for (int c = 0; c < 3; c++) begin
          if (cmd_i.idx == 2'd0) begin
            n_q[c] <= $signed(term[c][NW-1:0]);
          end else begin
            n_q[c] <= n_q[c] + $signed(term[c][NW-1:0]);
          end
        end
      end
      tss_pkg::OP_ABS: begin
        for (int c = 0; c < 3; c++) begin
          neg_q[c] <= n_q[c][NW-1];
          m_q[c]   <= MMW'(mag[c][MW-1:0]);
        end
      end
      tss_pkg::OP_RANGE: begin
        for (int c = 0; c < 3; c++) begin
          m_q[c] <= m_q[c] >> 1;
        end
      end
      tss_pkg::OP_SQ: begin
        prod_q <= sq;
        if (cmd_i.idx != 2'd0) begin
          sum_q <= acc;
        end
        if (cmd_i.idx == 2'd3) begin
          x_q <= acc;
          s_q <= '0;
        end
      end
      tss_pkg::OP_NORM: begin
        x_q <= x_q << 2;
        s_q <= s_q + 1'b1;
      end
      tss_pkg::OP_SQRT_INIT: begin
        rem_q <= x_q;
        res_q <= '0;
        bit_q <= 64'd1 << 62;
      end
      tss_pkg::OP_SQRT: begin
        if (rem_q >= root_try) begin
          rem_q <= rem_q - root_try;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      tss_pkg::OP_DIV_INIT: begin
        for (int c = 0; c < 3; c++) begin
          drem_q[c] <= num[c][47:0];
          quo_q[c]  <= '0;
        end
        ds_q <= 48'(res_q[31:0]) << 16;
      end
      tss_pkg::OP_DIV: begin
        for (int c = 0; c < 3; c++) begin
          if (drem_q[c] >= ds_q) begin
            drem_q[c] <= drem_q[c] - ds_q;
            quo_q[c]  <= {quo_q[c][14:0], 1'b1};
          end else begin
            quo_q[c]  <= {quo_q[c][14:0], 1'b0};
          end
        end
        ds_q <= ds_q >> 1;
      end
      default: begin
      end
    endcase
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == tss_pkg::OP_EMIT) begin
      if (degen) begin
        out_data_q <= {cmd_i.col, cmd_i.row, 48'd0};
      end else begin
        out_data_q <= {cmd_i.col, cmd_i.row, pc[2], pc[1], pc[0]};
      end
      out_user_q <= {degen, corner};
      out_last_q <= last;
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == tss_pkg::OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;
  assign out_last_o  = out_last_q;

  // status to the controller
  assign status_o.over     = over;
  assign status_o.sum_zero = degen;
  assign status_o.x_low    = (x_q[63:60] == 4'd0);
  assign status_o.out_free = !out_valid_q || out_ready_i;

endmodule
`default_nettype wire
